// ===== design/iir_df2t_pkg.sv =====
// Shared widths, command and register codes, and control types for the
// DF2T IIR filter. No dependencies; used by every module of the block.

package iir_df2t_pkg;

   localparam int TAPS_DEFAULT = 4;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int STATE_W  = 40;
   localparam int PROD_W   = 2 * COEF_W;
   localparam int ACC_W    = STATE_W + 2;
   localparam int FRAC_W   = 13;

   localparam int B_REG_W   = 64;
   localparam int A_REG_W   = 48;
   localparam int LEN_REG_W = 3;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CMD_W     = 2;
   localparam int IDX_W     = 2;

   localparam logic [B_REG_W-1:0]   B_RESET   = B_REG_W'(8192);
   localparam logic [A_REG_W-1:0]   A_RESET   = '0;
   localparam logic [LEN_REG_W-1:0] LEN_RESET = LEN_REG_W'(1);

   localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_B_COEFFS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COEFFS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_LENGTH = 2'd2;

   typedef struct packed {
      logic capture;
      logic mac_en;
      logic update_en;
   } ctrl_cmd_type;

endpackage

// ===== design/iir_df2t_ctrl.sv =====
// Sequencer for the DF2T IIR filter: capture, output multiply, state update.
// Depends on iir_df2t_pkg; drives the command struct into iir_df2t_datapath.

module iir_df2t_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output iir_df2t_pkg::ctrl_cmd_type  dp_cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       upd_go;
   logic       accept;

   assign upd_go    = (state_ff == ST_UPD) && !(rsp_valid_ff && rsp_stall);
   assign req_stall = !((state_ff == ST_IDLE) || upd_go);
   assign accept    = req_valid && !req_stall;

   assign dp_cmd.capture   = accept;
   assign dp_cmd.mac_en    = (state_ff == ST_MAC);
   assign dp_cmd.update_en = upd_go;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_valid_in = upd_go || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MAC;
         end
         ST_MAC: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_go) state_in = accept ? ST_MAC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/iir_df2t_datapath.sv =====
// Datapath of the DF2T IIR filter: coefficient registers, delay line, output
// multiply with rounding, per-tap state update lanes and the result register.
// Depends on iir_df2t_pkg; sequenced by iir_df2t_ctrl.

module iir_df2t_datapath #(
   parameter int TAPS = iir_df2t_pkg::TAPS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  iir_df2t_pkg::ctrl_cmd_type                  dp_cmd,
   input  logic                                        csr_write,
   input  logic [iir_df2t_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [iir_df2t_pkg::CSR_W-1:0]              csr_data,
   input  logic [iir_df2t_pkg::CMD_W-1:0]              req_command,
   input  logic signed [iir_df2t_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                                        req_run_start,
   input  logic [iir_df2t_pkg::IDX_W-1:0]              req_state_index,
   input  logic signed [iir_df2t_pkg::STATE_W-1:0]     req_state_value,
   output logic signed [iir_df2t_pkg::SAMPLE_W-1:0]    rsp_filtered,
   output logic                                        rsp_saturated,
   output logic signed [iir_df2t_pkg::STATE_W-1:0]     rsp_state_out
);

   localparam int SW  = iir_df2t_pkg::STATE_W;
   localparam int XW  = iir_df2t_pkg::SAMPLE_W;
   localparam int CW  = iir_df2t_pkg::COEF_W;
   localparam int PW  = iir_df2t_pkg::PROD_W;
   localparam int AW  = iir_df2t_pkg::ACC_W;
   localparam int LW  = iir_df2t_pkg::LEN_REG_W;
   localparam int NDL = TAPS - 1;

   localparam logic signed [AW-1:0] STATE_MAX = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] STATE_MIN = AW'(-(64'sd1 <<< (SW - 1)));
   localparam logic signed [AW-1:0] Y_MAX     = AW'((64'sd1 <<< (XW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] Y_MIN     = AW'(-(64'sd1 <<< (XW - 1)));
   localparam logic signed [AW-1:0] RND_HALF  = AW'(64'sd1 <<< (iir_df2t_pkg::FRAC_W - 1));

   logic [iir_df2t_pkg::B_REG_W-1:0]   b_coeffs_ff;
   logic [iir_df2t_pkg::A_REG_W-1:0]   a_coeffs_ff;
   logic [LW-1:0]                      filter_length_ff;

   logic [iir_df2t_pkg::CMD_W-1:0]     cmd_ff;
   logic signed [XW-1:0]               x_ff;
   logic                               run_start_ff;
   logic [iir_df2t_pkg::IDX_W-1:0]     idx_ff;
   logic signed [SW-1:0]               value_ff;

   logic signed [XW-1:0]               y_ff, y_in;
   logic                               yflag_ff, yflag_in;

   logic signed [SW-1:0]               dl_ff [NDL];
   logic signed [SW-1:0]               dl_in [NDL];

   logic signed [XW-1:0]               filtered_ff, filtered_in;
   logic                               saturated_ff, saturated_in;
   logic signed [SW-1:0]               state_out_ff, state_out_in;

   logic [LW-1:0]                      len;
   logic                               is_filter;
   logic                               clear;
   logic signed [SW-1:0]               z0;
   logic signed [PW-1:0]               b0x;
   logic signed [AW-1:0]               acc;
   logic signed [AW-1:0]               q;

   logic signed [SW-1:0]               lane_val  [NDL];
   logic                               lane_sat  [NDL];
   logic                               lane_used [NDL];

   assign is_filter = (cmd_ff == iir_df2t_pkg::CMD_FILTER);
   assign clear     = is_filter && run_start_ff;

   always_comb begin
      if (filter_length_ff == '0) begin
         len = LW'(1);
      end else if (filter_length_ff > LW'(TAPS)) begin
         len = LW'(TAPS);
      end else begin
         len = filter_length_ff;
      end
   end

   // output tap: y = round(b0*x + z0), saturated to the sample range
   assign z0  = (len > LW'(1) && !clear) ? dl_ff[0] : '0;
   assign b0x = $signed(b_coeffs_ff[CW-1:0]) * x_ff;
   assign acc = AW'(b0x) + AW'(z0) + RND_HALF;
   assign q   = acc >>> iir_df2t_pkg::FRAC_W;

   always_comb begin
      y_in     = y_ff;
      yflag_in = yflag_ff;
      if (dp_cmd.mac_en) begin
         yflag_in = 1'b0;
         if (q > Y_MAX) begin
            y_in     = XW'(Y_MAX);
            yflag_in = 1'b1;
         end else if (q < Y_MIN) begin
            y_in     = XW'(Y_MIN);
            yflag_in = 1'b1;
         end else begin
            y_in = XW'(q);
         end
      end
   end

   // one lane per delay entry: z(j) = b(j+1)*x - a(j+1)*y + z(j+1)
   for (genvar j = 0; j < NDL; j++) begin : g_lane
      logic signed [PW-1:0] bx;
      logic signed [PW-1:0] ay;
      logic signed [SW-1:0] nxt;
      logic signed [AW-1:0] sum;

      assign bx = $signed(b_coeffs_ff[CW*(j+1) +: CW]) * x_ff;
      assign ay = $signed(a_coeffs_ff[CW*j +: CW]) * y_ff;

      if (j + 1 < NDL) begin : g_next
         assign nxt = (LW'(j + 2) < len && !clear) ? dl_ff[j+1] : '0;
      end else begin : g_last
         assign nxt = '0;
      end

      assign sum          = AW'(bx) - AW'(ay) + AW'(nxt);
      assign lane_used[j] = LW'(j + 1) < len;

      always_comb begin
         if (sum > STATE_MAX) begin
            lane_val[j] = SW'(STATE_MAX);
            lane_sat[j] = 1'b1;
         end else if (sum < STATE_MIN) begin
            lane_val[j] = SW'(STATE_MIN);
            lane_sat[j] = 1'b1;
         end else begin
            lane_val[j] = SW'(sum);
            lane_sat[j] = 1'b0;
         end
      end
   end

   always_comb begin
      logic any_sat;
      any_sat      = 1'b0;
      filtered_in  = filtered_ff;
      saturated_in = saturated_ff;
      state_out_in = state_out_ff;
      for (int j = 0; j < NDL; j++) begin
         dl_in[j] = dl_ff[j];
      end
      if (dp_cmd.update_en) begin
         filtered_in  = '0;
         saturated_in = 1'b0;
         state_out_in = '0;
         case (cmd_ff)
            iir_df2t_pkg::CMD_FILTER: begin
               for (int j = 0; j < NDL; j++) begin
                  if (lane_used[j]) begin
                     dl_in[j] = lane_val[j];
                     any_sat  = any_sat | lane_sat[j];
                  end else if (clear) begin
                     dl_in[j] = '0;
                  end
               end
               filtered_in  = y_ff;
               saturated_in = yflag_ff | any_sat;
            end
            iir_df2t_pkg::CMD_WRITE: begin
               for (int j = 0; j < NDL; j++) begin
                  if (idx_ff == iir_df2t_pkg::IDX_W'(j)) dl_in[j] = value_ff;
               end
            end
            iir_df2t_pkg::CMD_READ: begin
               for (int j = 0; j < NDL; j++) begin
                  if (idx_ff == iir_df2t_pkg::IDX_W'(j)) state_out_in = dl_ff[j];
               end
            end
            default: begin
               filtered_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_coeffs_ff      <= iir_df2t_pkg::B_RESET;
         a_coeffs_ff      <= iir_df2t_pkg::A_RESET;
         filter_length_ff <= iir_df2t_pkg::LEN_RESET;
         for (int j = 0; j < NDL; j++) begin
            dl_ff[j] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               iir_df2t_pkg::CSR_B_COEFFS: begin
                  b_coeffs_ff <= csr_data[iir_df2t_pkg::B_REG_W-1:0];
               end
               iir_df2t_pkg::CSR_A_COEFFS: begin
                  a_coeffs_ff <= csr_data[iir_df2t_pkg::A_REG_W-1:0];
               end
               iir_df2t_pkg::CSR_FILTER_LENGTH: begin
                  filter_length_ff <= csr_data[LW-1:0];
               end
               default: begin
                  filter_length_ff <= filter_length_ff;
               end
            endcase
         end
         for (int j = 0; j < NDL; j++) begin
            dl_ff[j] <= dl_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff       <= req_command;
         x_ff         <= req_sample;
         run_start_ff <= req_run_start;
         idx_ff       <= req_state_index;
         value_ff     <= req_state_value;
      end
      y_ff         <= y_in;
      yflag_ff     <= yflag_in;
      filtered_ff  <= filtered_in;
      saturated_ff <= saturated_in;
      state_out_ff <= state_out_in;
   end

   assign rsp_filtered  = filtered_ff;
   assign rsp_saturated = saturated_ff;
   assign rsp_state_out = state_out_ff;

endmodule

// ===== design/iir_df2t_filter_top.sv =====
// Top level of the Direct Form II transposed IIR filter.
// Depends on iir_df2t_pkg, iir_df2t_ctrl and iir_df2t_datapath.
//
// Usage:
//   req_* is the input channel: one beat carries a command (filter one sample,
//   write a delay entry, read a delay entry), the sample, run_start, the entry
//   index and the entry value. rsp_* returns exactly one beat per request:
//   the rounded Q15 output with its saturation flag, or the entry read back.
//   csr_* writes b_coeffs, a_coeffs and filter_length; write only while idle.
//   Each request passes through capture, the output multiply (ST_MAC) and the
//   state update (ST_UPD), which writes the output register. A new request can
//   be taken in the update step of the previous one, but not during the output
//   multiply, which must finish before the delay update's feedback uses y.
//   A finished result sits in the output register while the next request is
//   taken and multiplied; if rsp_stall holds that result, the next update
//   waits and req_stall stays high until the register drains.
//   Reset loads b0 = 1.0, all other coefficients zero, filter_length 1 and
//   clears the delay line; the block is ready in the first cycle after reset.

module iir_df2t_filter_top #(
   parameter int TAPS = iir_df2t_pkg::TAPS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [iir_df2t_pkg::CMD_W-1:0]              req_command,
   input  logic signed [iir_df2t_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                                        req_run_start,
   input  logic [iir_df2t_pkg::IDX_W-1:0]              req_state_index,
   input  logic signed [iir_df2t_pkg::STATE_W-1:0]     req_state_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [iir_df2t_pkg::SAMPLE_W-1:0]    rsp_filtered,
   output logic                                        rsp_saturated,
   output logic signed [iir_df2t_pkg::STATE_W-1:0]     rsp_state_out,
   input  logic                                        csr_write,
   input  logic [iir_df2t_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [iir_df2t_pkg::CSR_W-1:0]              csr_data
);

   iir_df2t_pkg::ctrl_cmd_type dp_cmd;

   iir_df2t_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   iir_df2t_datapath #(
      .TAPS (TAPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_command     (req_command),
      .req_sample      (req_sample),
      .req_run_start   (req_run_start),
      .req_state_index (req_state_index),
      .req_state_value (req_state_value),
      .rsp_filtered    (rsp_filtered),
      .rsp_saturated   (rsp_saturated),
      .rsp_state_out   (rsp_state_out)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ##2 rsp_valid)
      else $error("no result two cycles after request beat");

   a_no_accept_in_mac: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.mac_en |-> req_stall)
      else $error("request taken during output multiply");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.update_en |-> !(rsp_valid && rsp_stall))
      else $error("update while result held by receiver");

   a_capture_alone: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |-> !dp_cmd.mac_en)
      else $error("capture overlaps output multiply");

endmodule
